FILE: rtl/matrix3_inverse_top_macros.svh
// assertion macros for the 3x3 inverse block
`ifndef MATRIX3_INVERSE_TOP_MACROS_SVH
`define MATRIX3_INVERSE_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define M3I_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3i check failed");

// consequent must hold in the cycle after the antecedent
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m3i check failed");

`endif

FILE: rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// shared types and constants of the 3x3 matrix inverse
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int MAT_DIM   = 3;
    localparam int NUM_LANES = MAT_DIM * MAT_DIM;

    // status of one lane's quotient
    typedef struct packed {
        logic neg;  // result is negative
        logic ovf;  // quotient magnitude at least 2^word_bits
    } t_lane_flags;

endpackage

FILE: rtl/m3i_lane.sv
// ----------------------------------------------------------------------------
// m3i_lane
// one adjugate entry: signed 2x2 cofactor, then a pipelined restoring
// divide of the cofactor scaled by 2^(2*frac) by the determinant
// ----------------------------------------------------------------------------
module m3i_lane #(
    parameter int W   = 32,
    parameter int F   = 16,
    parameter bit NEG = 1'b0
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [W-1:0]      i_k0,
    input  logic signed [W-1:0]      i_k1,
    input  logic signed [W-1:0]      i_k2,
    input  logic signed [W-1:0]      i_k3,
    input  logic signed [3*W+2:0]    i_det,
    output logic signed [2*W:0]      o_cof,
    output logic [W-1:0]             o_q,
    output m3i_pkg::t_lane_flags     o_flags
);
    localparam int CFW = 2 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = CFW + 2 * F;
    localparam int CW  = ((NW > DW + W) ? NW : DW + W) + 1;

    logic signed [2*W-1:0] r_p0, r_p1;
    logic signed [CFW-1:0] r_cof;
    logic signed [CFW-1:0] r_cof_d [0:1];
    logic [NW-1:0]         r_rem   [0:W];
    logic [DW-1:0]         r_dv    [0:W];
    logic [W-1:0]          r_q     [0:W];
    logic                  r_neg   [0:W];
    logic                  r_ovf   [0:W];

    logic [CFW-1:0] cof_abs;
    logic [DW-1:0]  det_abs;
    logic [NW-1:0]  n_num;
    logic [CW-1:0]  ovf_lim;

    always_comb begin
        cof_abs = r_cof_d[1][CFW-1] ? CFW'(-r_cof_d[1]) : CFW'(r_cof_d[1]);
        det_abs = i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
        n_num   = {cof_abs, {(2*F){1'b0}}};
        ovf_lim = CW'(det_abs) << W;
    end

    // cofactor, then align with the determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0       <= i_k0 * i_k3;
            r_p1       <= i_k1 * i_k2;
            r_cof      <= NEG ? (CFW'(r_p1) - CFW'(r_p0)) : (CFW'(r_p0) - CFW'(r_p1));
            r_cof_d[0] <= r_cof;
            r_cof_d[1] <= r_cof_d[0];
            r_rem[0]   <= n_num;
            r_dv[0]    <= det_abs;
            r_q[0]     <= '0;
            r_neg[0]   <= r_cof_d[1][CFW-1] ^ i_det[DW-1];
            r_ovf[0]   <= CW'(n_num) >= ovf_lim;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= W; k++) begin : g_div
        logic [CW-1:0] shd;
        logic [CW-1:0] diff;
        logic          ge;
        assign shd  = CW'(r_dv[k-1]) << (W - k);
        assign diff = CW'(r_rem[k-1]) - shd;
        assign ge   = !diff[CW-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[NW-1:0] : r_rem[k-1];
                r_dv[k]  <= r_dv[k-1];
                r_q[k]   <= {r_q[k-1][W-2:0], ge};
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_cof       = r_cof;
    assign o_q         = r_q[W];
    assign o_flags.neg = r_neg[W];
    assign o_flags.ovf = r_ovf[W];

endmodule

FILE: rtl/matrix3_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_top
// inverse of a 3x3 signed fixed-point matrix through the adjugate
// ----------------------------------------------------------------------------
// One matrix transfer can be taken every clock cycle while the pipeline
// moves; the divider resolves one quotient bit per stage in each of the
// nine lanes. The whole pipeline moves only when the output register is
// empty or being taken. A zero determinant gives an all-zero matrix with
// tuser low; quotients are truncated toward zero and saturated.
`include "matrix3_inverse_top_macros.svh"

module matrix3_inverse_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // a11, a12, a13, a21, a22, a23, a31, a32, a33 from the lowest bit up
    input  logic [((9*WORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // b11, b12, b13, b21, b22, b23, b31, b32, b33 from the lowest bit up
    output logic [((9*WORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // invertible
    output logic                 o_m_axis_tuser
);
    localparam int W    = WORD_BITS;
    localparam int NL   = m3i_pkg::NUM_LANES;
    localparam int MD   = m3i_pkg::MAT_DIM;
    localparam int TDW  = ((9 * W + 7) / 8) * 8;
    localparam int CFW  = 2 * W + 1;
    localparam int DW   = 3 * W + 3;
    localparam int NST  = W + 7;

    logic en;
    logic r_vld [0:NST-1];
    logic signed [W-1:0]     r_a   [0:NL-1];
    logic signed [W-1:0]     r_a1d [0:1][0:MD-1];
    logic signed [2*W:0]     r_plo [0:MD-1];
    logic signed [2*W:0]     r_phi [0:MD-1];
    logic signed [DW-1:0]    r_det;
    logic                    r_sing [0:W];
    logic [TDW-1:0]          r_out_data;
    logic                    r_out_user;

    logic signed [CFW-1:0]   cof   [0:NL-1];
    logic [W-1:0]            q     [0:NL-1];
    m3i_pkg::t_lane_flags    flags [0:NL-1];
    logic [TDW-1:0]          n_out_data;
    logic signed [DW-1:0]    n_det;

    assign en              = !r_vld[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int i = 1; i < NST; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // input register and the first row kept for the determinant
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) r_a[i] <= i_s_axis_tdata[i*W +: W];
            for (int j = 0; j < MD; j++) begin
                r_a1d[0][j] <= r_a[j];
                r_a1d[1][j] <= r_a1d[0][j];
            end
        end
    end

    // lane r*3+c gives inverse entry (r, c): cofactor of element (c, r)
    for (genvar r = 0; r < MD; r++) begin : g_row
        for (genvar c = 0; c < MD; c++) begin : g_col
            localparam int I0 = (c == 0) ? 1 : 0;
            localparam int I1 = (c == 2) ? 1 : 2;
            localparam int J0 = (r == 0) ? 1 : 0;
            localparam int J1 = (r == 2) ? 1 : 2;
            m3i_lane #(
                .W   (W),
                .F   (FRAC_BITS),
                .NEG (((r + c) % 2) == 1)
            ) u_lane (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_k0    (r_a[I0*MD + J0]),
                .i_k1    (r_a[I0*MD + J1]),
                .i_k2    (r_a[I1*MD + J0]),
                .i_k3    (r_a[I1*MD + J1]),
                .i_det   (r_det),
                .o_cof   (cof[r*MD + c]),
                .o_q     (q[r*MD + c]),
                .o_flags (flags[r*MD + c])
            );
        end
    end

    // determinant by expansion along the first row, cofactor split in two
    always_comb begin
        n_det = '0;
        for (int j = 0; j < MD; j++) begin
            n_det = n_det + (DW'(r_phi[j]) <<< W) + DW'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < MD; j++) begin
                r_plo[j] <= r_a1d[1][j] * $signed({1'b0, cof[j*MD][W-1:0]});
                r_phi[j] <= r_a1d[1][j] * $signed(cof[j*MD][CFW-1:W]);
            end
            r_det     <= n_det;
            r_sing[0] <= (r_det == '0);
            for (int i = 1; i <= W; i++) r_sing[i] <= r_sing[i-1];
        end
    end

    // saturation, sign and singular mask
    always_comb begin
        n_out_data = '0;
        for (int l = 0; l < NL; l++) begin
            logic [W-1:0] v;
            if (!flags[l].neg) begin
                if (flags[l].ovf || q[l][W-1]) v = {1'b0, {(W-1){1'b1}}};
                else                           v = q[l];
            end else begin
                if (flags[l].ovf || (q[l][W-1] && (q[l][W-2:0] != '0)))
                    v = {1'b1, {(W-1){1'b0}}};
                else
                    v = W'(-q[l]);
            end
            if (r_sing[W]) v = '0;
            n_out_data[l*W +: W] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_user <= !r_sing[W];
        end
    end

    `M3I_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    `M3I_ASSERT_NOW(a_singular_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == '0)
    `M3I_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule
